### hdl/pfcd_pkg.sv
// Shared types, constants and the CRC-8 byte update for the frame decoder.
package pfcd_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_WORD1_ERR = 2'd1;
  localparam status_t ST_WORD2_ERR = 2'd2;

  typedef logic [3:0] pos_t;

  // byte positions inside the nine-byte frame
  localparam pos_t POS_HI    = 4'd0;
  localparam pos_t POS_LO    = 4'd1;
  localparam pos_t POS_CRC1  = 4'd2;
  localparam pos_t POS_W2_HI = 4'd3;
  localparam pos_t POS_W2_LO = 4'd4;
  localparam pos_t POS_CRC2  = 4'd5;
  localparam pos_t POS_LAST  = 4'd8;
  localparam pos_t POS_IDLE  = 4'd9;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // floor(n / 15) as (n * FLOW_RECIP) >> FLOW_SHIFT, exact for n < 2^21
  localparam int FLOW_SHIFT = 25;
  localparam logic [21:0] FLOW_RECIP = 22'd2236963;

  typedef struct packed {
    logic           last;    // accepted byte is the ninth of its frame
    status_t        status;
    logic [15:0]    word;
  } frame_done_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hdl/pfcd_frame.sv
// Frame tracker: byte position, running CRC, captured first word, error flag.
module pfcd_frame (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  input  logic                  frame_start,
  output logic [15:0]           word,
  output pfcd_pkg::frame_done_t done
);
  import pfcd_pkg::*;

  pos_t        pos, pos_next;
  logic [7:0]  crc, crc_next;
  logic [15:0] word_next;
  status_t     err, err_next;

  pos_t        p_eff;
  logic [7:0]  crc_eff;
  logic [15:0] word_eff;
  status_t     err_eff;

  always_comb begin
    p_eff    = frame_start ? POS_HI : pos;
    crc_eff  = frame_start ? CRC_INIT : crc;
    word_eff = frame_start ? 16'd0 : word;
    err_eff  = frame_start ? ST_OK : err;

    pos_next  = pos;
    crc_next  = crc;
    word_next = word;
    err_next  = err;

    if (accept && p_eff < POS_IDLE) begin
      pos_next  = (p_eff == POS_LAST) ? POS_IDLE : p_eff + 4'd1;
      crc_next  = crc_eff;
      word_next = word_eff;
      err_next  = err_eff;
      unique case (p_eff)
        POS_HI: begin
          word_next = {rx_byte, word_eff[7:0]};
          crc_next  = crc8_byte(crc_eff, rx_byte);
        end
        POS_LO: begin
          word_next = {word_eff[15:8], rx_byte};
          crc_next  = crc8_byte(crc_eff, rx_byte);
        end
        POS_W2_HI, POS_W2_LO: begin
          crc_next = crc8_byte(crc_eff, rx_byte);
        end
        POS_CRC1: begin
          if (crc_eff != rx_byte && err_eff == ST_OK) err_next = ST_WORD1_ERR;
          crc_next = CRC_INIT;
        end
        POS_CRC2: begin
          if (crc_eff != rx_byte && err_eff == ST_OK) err_next = ST_WORD2_ERR;
          crc_next = CRC_INIT;
        end
        default: ;
      endcase
    end
  end

  assign done.last   = accept && (p_eff == POS_LAST);
  assign done.status = err_eff;
  assign done.word   = word_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= POS_HI;
      crc  <= CRC_INIT;
      word <= 16'd0;
      err  <= ST_OK;
    end else begin
      pos  <= pos_next;
      crc  <= crc_next;
      word <= word_next;
      err  <= err_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= POS_IDLE)
    else $error("frame position out of range");
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (pos == POS_IDLE && !(accept && frame_start)) |=> pos == POS_IDLE)
    else $error("left idle without a frame start");
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (err != ST_OK && !(accept && frame_start)) |=> $stable(err))
    else $error("frame error changed inside a frame");

endmodule

### hdl/pfcd_flow.sv
// Flow scaler: signed word times 32/15, rounded, as Q10.8, two register stages.
module pfcd_flow (
  input  logic               clk,
  input  logic [15:0]        word,
  output logic signed [17:0] flow
);
  import pfcd_pkg::*;

  logic        neg;
  logic [15:0] mag;
  logic [20:0] num;
  logic [42:0] prod;
  logic [17:0] q;

  // stage 1: sign and magnitude
  always_ff @(posedge clk) begin
    neg <= word[15];
    mag <= word[15] ? 16'(~word + 16'd1) : word;
  end

  // round(m*32/15) == floor((32m + 7) / 15)
  assign num  = {mag, 5'b0} + 21'd7;
  assign prod = {22'd0, num} * {21'd0, FLOW_RECIP};
  assign q    = prod[FLOW_SHIFT +: 18];

  // stage 2: scaled and signed
  always_ff @(posedge clk) begin
    flow <= neg ? -$signed(q) : $signed(q);
  end

endmodule

### hdl/pressure_frame_crc_flow_decoder_core.sv
// Top level of the nine-byte pressure frame decoder with CRC-8 check and flow scaling.
// Takes one received byte per word on the input channel, one word per clock cycle with
// no gaps required; frame_start marks byte 0 of a frame (after reset the decoder already
// sits at byte 0). A frame is three groups of two data bytes and a CRC-8 byte (poly 0x31,
// init 0xFF, MSB first); the first two groups are checked, the third is ignored. The ninth
// byte yields one result word: status (0 ok, 1 first CRC bad, 2 second CRC bad; first
// wins), raw_flow (first data word, big-endian, signed) and flow_lpm_q8 = raw/120 L/min as
// signed Q10.8, rounded to nearest, forced to 0 on a CRC error. Bytes after the ninth are
// swallowed until the next frame_start. Throughput is one byte per cycle while the input is
// ready: the CRC update is a single unrolled byte step, and the flow scaling runs in a
// two-stage pipeline that follows the captured word, long finished before the ninth byte
// arrives. The result is loaded into the output register in the cycle after the ninth byte,
// and the input stays ready while that register is empty or being read.
module pressure_frame_crc_flow_decoder_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               rx_byte,
  input  logic                     frame_start,
  output logic                     out_valid,
  input  logic                     out_ready,
  output pfcd_pkg::status_t        status,
  output logic signed [15:0]       raw_flow,
  output logic signed [17:0]       flow_lpm_q8
);
  import pfcd_pkg::*;

  logic               accept;
  logic [15:0]        word;
  frame_done_t        done;
  logic signed [17:0] flow;

  // output register frees up when empty or drained this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // position, CRC and first-word capture
  pfcd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .word        (word),
    .done        (done)
  );

  // word is stable from byte 2 on, so flow is settled by byte 8
  pfcd_flow u_flow (
    .clk  (clk),
    .word (word),
    .flow (flow)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= done.last;
    end
  end

  // result payload, loaded only on the ninth byte
  always_ff @(posedge clk) begin
    if (done.last) begin
      status      <= done.status;
      raw_flow    <= $signed(done.word);
      flow_lpm_q8 <= (done.status == ST_OK) ? flow : 18'sd0;
    end
  end

  a_err_zero_flow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> flow_lpm_q8 == 18'sd0)
    else $error("flow not zero on CRC error");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_WORD1_ERR || status == ST_WORD2_ERR))
    else $error("undefined status code");
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    done.last |=> out_valid)
    else $error("ninth byte gave no result");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule
